// ===== rtl/hte_pkg.sv =====
// Shared types and constants for the Huffman tree build and encode unit.
// No dependencies.
package hte_pkg;

	localparam int SYMBOLS      = 256;
	localparam int SYM_W        = 8;
	localparam int NODES        = 2 * SYMBOLS;
	localparam int NODE_W       = 9;
	localparam int COUNT_W      = 32;
	localparam int MAX_CODE_LEN = 32;
	localparam int CODE_POS_W   = 5;
	localparam int CODE_LEN_W   = 6;
	localparam int DEPTH_W      = 9;
	localparam int FILL_W       = 9;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_COUNT  = 2'd1;
	localparam logic [1:0] KIND_ENCODE = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [SYM_W-1:0] byte_value;
		logic             last;
	} in_item_t;

	typedef struct packed {
		logic [MAX_CODE_LEN-1:0] code_bits;
		logic [CODE_LEN_W-1:0]   code_length;
		logic                    symbol_unseen;
		logic                    too_long;
	} out_item_t;

	typedef struct packed {
		logic [NODE_W-1:0]  node;
		logic [COUNT_W-1:0] freq;
	} qent_t;

	typedef struct packed {
		logic [NODE_W-1:0] parent;
		logic              right;
	} nent_t;

	typedef struct packed {
		logic ld_item;
		logic clr;
		logic cnt_wr;
		logic clr_ready;
		logic fill_init;
		logic fill_scan;
		logic fill_wr;
		logic pop_init;
		logic pop_rd;
		logic pop_cmp;
		logic last_rd;
		logic last_wr;
		logic par_a;
		logic par_b;
		logic set_ready;
		logic enc_chk;
		logic walk_use;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic fill_done;
		logic scan_done;
		logic fill_ge2;
		logic pop_b;
		logic last;
		logic unseen;
		logic at_root;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/hte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/hte_ctrl.sv =====
// Sequencer for clear, count, tree build, and encode walk.
// Depends on hte_pkg.
module hte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [1:0]        item_kind,
	output logic              item_stall,
	input  hte_pkg::status_t  st,
	output hte_pkg::cmd_t     cmd
);
	import hte_pkg::*;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_CNT_RD   = 5'd1;
	localparam logic [4:0] S_CNT_WR   = 5'd2;
	localparam logic [4:0] S_FILL_RD  = 5'd3;
	localparam logic [4:0] S_FILL_WR  = 5'd4;
	localparam logic [4:0] S_MERGE    = 5'd5;
	localparam logic [4:0] S_POP_RD   = 5'd6;
	localparam logic [4:0] S_POP_CMP  = 5'd7;
	localparam logic [4:0] S_LAST_RD  = 5'd8;
	localparam logic [4:0] S_LAST_WR  = 5'd9;
	localparam logic [4:0] S_PAR_A    = 5'd10;
	localparam logic [4:0] S_PAR_B    = 5'd11;
	localparam logic [4:0] S_ENC_RD   = 5'd12;
	localparam logic [4:0] S_ENC_CHK  = 5'd13;
	localparam logic [4:0] S_WALK_RD  = 5'd14;
	localparam logic [4:0] S_WALK_USE = 5'd15;
	localparam logic [4:0] S_EMIT     = 5'd16;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.ld_item = 1'b1;
					unique case (item_kind)
						KIND_CLEAR:  cmd.clr = 1'b1;
						KIND_COUNT:  state_d = S_CNT_RD;
						KIND_ENCODE: state_d = S_ENC_RD;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_CNT_RD: state_d = S_CNT_WR;
			S_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				if (st.last) begin
					cmd.fill_init = 1'b1;
					state_d = S_FILL_RD;
				end else begin
					cmd.clr_ready = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FILL_RD: begin
				cmd.fill_scan = 1'b1;
				state_d = S_FILL_WR;
			end
			S_FILL_WR: begin
				cmd.fill_scan = 1'b1;
				cmd.fill_wr = 1'b1;
				state_d = st.fill_done ? S_MERGE : S_FILL_RD;
			end
			S_MERGE: begin
				if (st.fill_ge2) begin
					cmd.pop_init = 1'b1;
					state_d = S_POP_RD;
				end else begin
					cmd.set_ready = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d = S_POP_CMP;
			end
			S_POP_CMP: begin
				cmd.pop_cmp = 1'b1;
				state_d = st.scan_done ? S_LAST_RD : S_POP_RD;
			end
			S_LAST_RD: begin
				cmd.last_rd = 1'b1;
				state_d = S_LAST_WR;
			end
			S_LAST_WR: begin
				cmd.last_wr = 1'b1;
				if (st.pop_b) begin
					state_d = S_PAR_A;
				end else begin
					cmd.pop_init = 1'b1;
					state_d = S_POP_RD;
				end
			end
			S_PAR_A: begin
				cmd.par_a = 1'b1;
				state_d = S_PAR_B;
			end
			S_PAR_B: begin
				cmd.par_b = 1'b1;
				state_d = S_MERGE;
			end
			S_ENC_RD: state_d = S_ENC_CHK;
			S_ENC_CHK: begin
				cmd.enc_chk = 1'b1;
				state_d = st.unseen ? S_EMIT : S_WALK_RD;
			end
			S_WALK_RD: state_d = st.at_root ? S_EMIT : S_WALK_USE;
			S_WALK_USE: begin
				cmd.walk_use = 1'b1;
				state_d = S_WALK_RD;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/hte_dp.sv =====
// Datapath: histogram, build queue, node links, walk registers, result register.
// Depends on hte_pkg and hte_ram.
module hte_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hte_pkg::in_item_t    item,
	input  hte_pkg::cmd_t        cmd,
	output hte_pkg::status_t     st,
	output hte_pkg::out_item_t   result,
	output logic                 result_valid,
	input  logic                 result_stall
);
	import hte_pkg::*;

	logic [SYM_W-1:0]   byte_q;
	logic               last_q;
	logic [SYMBOLS-1:0] hist_vld_q;
	logic [SYM_W-1:0]   s_q;
	logic [FILL_W-1:0]  fill_q;
	logic [SYM_W-1:0]   i_q;
	logic [SYM_W-1:0]   best_idx_q;
	qent_t              best_q;
	qent_t              a_q;
	qent_t              b_q;
	logic               pop_b_q;
	logic [NODE_W-1:0]  next_q;
	logic [NODE_W-1:0]  root_q;
	logic               ready_q;
	logic [NODE_W-1:0]  node_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [MAX_CODE_LEN-1:0] code_q;
	logic               unseen_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [SYM_W-1:0]   hist_addr;
	logic [COUNT_W-1:0] hist_rdata;
	logic [COUNT_W-1:0] hist_val;
	logic [COUNT_W-1:0] hist_inc;
	logic               hist_we;

	logic [SYM_W-1:0]   q_raddr;
	logic [SYM_W-1:0]   q_waddr;
	qent_t              q_rdata;
	qent_t              q_wdata;
	logic               q_we;
	logic [FILL_W-1:0]  fill_m1;
	logic [COUNT_W:0]   sum_full;
	logic [COUNT_W-1:0] sum_sat;
	logic               take;

	logic [NODE_W-1:0]  n_waddr;
	nent_t              n_wdata;
	nent_t              n_rdata;
	logic               n_we;
	logic               too_long;

	assign hist_addr = cmd.fill_scan ? s_q : byte_q;
	assign hist_val  = hist_vld_q[hist_addr] ? hist_rdata : '0;
	assign hist_inc  = (hist_val == {COUNT_W{1'b1}}) ? hist_val : hist_val + 1'b1;
	assign hist_we   = cmd.cnt_wr;

	hte_ram #(.WIDTH(COUNT_W), .DEPTH(SYMBOLS)) u_hist (
		.clk     (clk),
		.wr_en   (hist_we),
		.wr_addr (byte_q),
		.wr_data (hist_inc),
		.rd_addr (hist_addr),
		.rd_data (hist_rdata)
	);

	assign fill_m1  = fill_q - 1'b1;
	assign sum_full = {1'b0, a_q.freq} + {1'b0, b_q.freq};
	assign sum_sat  = sum_full[COUNT_W] ? {COUNT_W{1'b1}} : sum_full[COUNT_W-1:0];
	assign q_raddr  = cmd.last_rd ? fill_m1[SYM_W-1:0] : i_q;

	always_comb begin
		q_we = 1'b0;
		q_waddr = fill_q[SYM_W-1:0];
		q_wdata = q_rdata;
		priority if (cmd.fill_wr) begin
			q_we = (hist_val != '0);
			q_wdata.node = {1'b0, s_q};
			q_wdata.freq = hist_val;
		end else if (cmd.last_wr) begin
			q_we = 1'b1;
			q_waddr = best_idx_q;
		end else if (cmd.par_b) begin
			q_we = 1'b1;
			q_wdata.node = next_q;
			q_wdata.freq = sum_sat;
		end
	end

	hte_ram #(.WIDTH($bits(qent_t)), .DEPTH(SYMBOLS)) u_queue (
		.clk     (clk),
		.wr_en   (q_we),
		.wr_addr (q_waddr),
		.wr_data (q_wdata),
		.rd_addr (q_raddr),
		.rd_data (q_rdata)
	);

	assign take = (i_q == '0) || (q_rdata.freq < best_q.freq) ||
		((q_rdata.freq == best_q.freq) && (q_rdata.node < best_q.node));

	assign n_we    = cmd.par_a | cmd.par_b;
	assign n_waddr = cmd.par_b ? b_q.node : a_q.node;
	assign n_wdata = '{parent: next_q, right: cmd.par_b};

	hte_ram #(.WIDTH($bits(nent_t)), .DEPTH(NODES)) u_node (
		.clk     (clk),
		.wr_en   (n_we),
		.wr_addr (n_waddr),
		.wr_data (n_wdata),
		.rd_addr (node_q),
		.rd_data (n_rdata)
	);

	assign too_long = (depth_q > DEPTH_W'(MAX_CODE_LEN));

	assign st.fill_done = (s_q == {SYM_W{1'b1}});
	assign st.scan_done = ({1'b0, i_q} == fill_m1);
	assign st.fill_ge2  = (fill_q >= FILL_W'(2));
	assign st.pop_b     = pop_b_q;
	assign st.last      = last_q;
	assign st.unseen    = !ready_q || (hist_val == '0);
	assign st.at_root   = (node_q == root_q);
	assign st.out_free  = !out_valid_q || !result_stall;

	assign result       = out_q;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q  <= '0;
			s_q         <= '0;
			fill_q      <= '0;
			i_q         <= '0;
			pop_b_q     <= 1'b0;
			next_q      <= NODE_W'(SYMBOLS);
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				hist_vld_q <= '0;
				ready_q <= 1'b0;
			end
			if (cmd.cnt_wr) begin
				hist_vld_q[byte_q] <= 1'b1;
			end
			if (cmd.clr_ready) begin
				ready_q <= 1'b0;
			end
			if (cmd.set_ready) begin
				ready_q <= 1'b1;
			end
			if (cmd.fill_init) begin
				s_q <= '0;
				fill_q <= '0;
				next_q <= NODE_W'(SYMBOLS);
				pop_b_q <= 1'b0;
				ready_q <= 1'b0;
			end
			if (cmd.fill_wr) begin
				s_q <= s_q + 1'b1;
				if (hist_val != '0) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.pop_init) begin
				i_q <= '0;
			end
			if (cmd.pop_cmp) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.last_wr) begin
				fill_q <= fill_m1;
				pop_b_q <= !pop_b_q;
			end
			if (cmd.par_b) begin
				fill_q <= fill_q + 1'b1;
				next_q <= next_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			byte_q <= item.byte_value;
			last_q <= item.last;
		end
		if (cmd.fill_wr && (hist_val != '0)) begin
			root_q <= {1'b0, s_q};
		end
		if (cmd.par_b) begin
			root_q <= next_q;
		end
		if (cmd.pop_cmp && take) begin
			best_q <= q_rdata;
			best_idx_q <= i_q;
		end
		if (cmd.last_wr) begin
			if (pop_b_q) begin
				b_q <= best_q;
			end else begin
				a_q <= best_q;
			end
		end
		if (cmd.enc_chk) begin
			node_q <= {1'b0, byte_q};
			depth_q <= '0;
			code_q <= '0;
			unseen_q <= st.unseen;
		end
		if (cmd.walk_use) begin
			if (depth_q < DEPTH_W'(MAX_CODE_LEN)) begin
				code_q[depth_q[CODE_POS_W-1:0]] <= n_rdata.right;
			end
			depth_q <= depth_q + 1'b1;
			node_q <= n_rdata.parent;
		end
		if (cmd.emit) begin
			out_q.code_bits <= too_long ? '0 : code_q;
			out_q.code_length <= too_long ? '0 : depth_q[CODE_LEN_W-1:0];
			out_q.symbol_unseen <= unseen_q;
			out_q.too_long <= too_long;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(SYMBOLS))
		else $error("queue fill above symbol count");

	a_next_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_q >= NODE_W'(SYMBOLS))
		else $error("internal node number below symbol range");

	a_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.too_long |-> out_q.code_length == '0 && out_q.code_bits == '0)
		else $error("too_long result carries a code");

	a_unseen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.symbol_unseen |-> out_q.code_bits == '0 && !out_q.too_long)
		else $error("unseen result carries a code");

endmodule

// ===== rtl/huffman_tree_build_and_encode_unit.sv =====
// Huffman tree build and encode unit over a byte alphabet. A request of kind clear
// is handled in the idle state. A count request reads and writes back one histogram
// entry; with last set it then builds the tree: it loads the queue with each symbol of
// nonzero count, then for each merge runs two linear minimum searches over the queue
// (a read and a compare per entry) and writes the parent links and the new node.
// An encode request checks the symbol, then walks from leaf to root through the node
// RAM, one level per code bit (up to 255 levels), then one result is held until taken.
// Depends on hte_pkg, hte_ctrl, hte_dp.
module huffman_tree_build_and_encode_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  hte_pkg::in_item_t   item,
	input  logic                item_valid,
	output logic                item_stall,
	output hte_pkg::out_item_t  result,
	output logic                result_valid,
	input  logic                result_stall
);
	import hte_pkg::*;

	cmd_t    cmd;
	status_t st;

	hte_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_kind  (item.kind),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	hte_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.st           (st),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

// ===== tb/huffman_tree_build_and_encode_unit_test.sv =====
// Testbench for huffman_tree_build_and_encode_unit: histogram, tree build and encode
// requests are checked against an in-bench Huffman predictor, under random idling.
// Depends on hte_pkg and the unit's RTL.
module huffman_tree_build_and_encode_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hte_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [NODE_W-1:0] NO_PARENT = '1;
	localparam int IDLE_LIMIT = 1500000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	in_item_t  item = '0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	out_item_t result;
	logic      result_valid;
	logic      result_stall = 1'b0;

	huffman_tree_build_and_encode_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item(item), .item_valid(item_valid), .item_stall(item_stall),
		.result(result), .result_valid(result_valid), .result_stall(result_stall)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [COUNT_W-1:0] hist [SYMBOLS];
	logic [NODE_W-1:0]  parent_of [NODES];
	bit                 is_right [NODES];
	logic [NODE_W-1:0]  q_node [SYMBOLS];
	logic [COUNT_W-1:0] q_freq [SYMBOLS];
	int                 q_fill;
	int                 next_node;
	bit                 tree_valid;

	out_item_t codes_due [$];
	int errors = 0;
	int n_sent = 0, n_codes = 0, n_builds = 0;
	int burst_left = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
		$display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
		errors++;
	endtask

	function automatic void tree_unlink();
		for (int i = 0; i < NODES; i++) begin
			parent_of[i] = NO_PARENT;
			is_right[i] = 0;
		end
		q_fill = 0;
		next_node = SYMBOLS;
		tree_valid = 0;
	endfunction

	function automatic void q_push(int n, logic [COUNT_W-1:0] f);
		if (q_fill < SYMBOLS) begin
			q_node[q_fill] = NODE_W'(n);
			q_freq[q_fill] = f;
			q_fill++;
		end
	endfunction

	function automatic void q_pop_min(output int n, output logic [COUNT_W-1:0] f);
		int best;
		best = 0;
		for (int i = 1; i < q_fill; i++)
			if (q_freq[i] < q_freq[best] ||
			    (q_freq[i] == q_freq[best] && q_node[i] < q_node[best]))
				best = i;
		n = int'(q_node[best]);
		f = q_freq[best];
		q_fill--;
		q_node[best] = q_node[q_fill];
		q_freq[best] = q_freq[q_fill];
	endfunction

	function automatic void tree_build();
		int na, nb, p;
		logic [COUNT_W-1:0] fa, fb;
		logic [COUNT_W:0] sum;
		tree_unlink();
		for (int s = 0; s < SYMBOLS; s++)
			if (hist[s] != 0) q_push(s, hist[s]);
		while (q_fill >= 2) begin
			q_pop_min(na, fa);
			q_pop_min(nb, fb);
			p = next_node;
			if (p >= NODES) break;
			next_node++;
			parent_of[na] = NODE_W'(p);
			is_right[na] = 0;
			parent_of[nb] = NODE_W'(p);
			is_right[nb] = 1;
			sum = {1'b0, fa} + {1'b0, fb};
			q_push(p, (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0]);
		end
		tree_valid = 1;
	endfunction

	function automatic out_item_t code_of(logic [SYM_W-1:0] b);
		out_item_t o;
		int node, depth, steps;
		logic [63:0] code;
		o = '0;
		code = 0;
		depth = 0;
		if (!tree_valid || hist[b] == 0) begin
			o.symbol_unseen = 1;
			return o;
		end
		node = int'(b);
		for (steps = 0; steps < NODES && parent_of[node] != NO_PARENT; steps++) begin
			if (depth < MAX_CODE_LEN && is_right[node]) code[depth] = 1'b1;
			depth++;
			node = int'(parent_of[node]);
		end
		if (depth > MAX_CODE_LEN) o.too_long = 1;
		else begin
			o.code_bits = code[MAX_CODE_LEN-1:0];
			o.code_length = CODE_LEN_W'(depth);
		end
		return o;
	endfunction

	function automatic void predict(in_item_t r);
		case (r.kind)
			KIND_CLEAR: begin
				for (int i = 0; i < SYMBOLS; i++) hist[i] = 0;
				tree_unlink();
			end
			KIND_COUNT: begin
				if (hist[r.byte_value] != COUNT_MAX) hist[r.byte_value]++;
				if (r.last) begin
					tree_build();
					n_builds++;
				end else tree_valid = 0;
			end
			KIND_ENCODE: begin
				codes_due.insert(codes_due.size(), code_of(r.byte_value));
				n_codes++;
			end
			default: ;
		endcase
	endfunction

	// one request; called at a rising edge, returns at a rising edge
	task automatic send_req(logic [1:0] kind, logic [SYM_W-1:0] b, logic last);
		int gap;
		in_item_t r;
		r.kind = kind;
		r.byte_value = b;
		r.last = last;
		item <= r;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		predict(r);
		n_sent++;
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(0, 12);
			gap = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		burst_left = 0;
		while (codes_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// receiver stall pattern, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if ((n_sent / 64) % 3 == 2)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(0, 2) == 0);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (codes_due.size() == 0) begin
				report_mismatch("unexpected result", 0, result);
			end else begin
				want = codes_due.pop_front();
				if (result.code_bits !== want.code_bits)
					report_mismatch("code_bits", want.code_bits, result.code_bits);
				if (result.code_length !== want.code_length)
					report_mismatch("code_length", want.code_length, result.code_length);
				if (result.symbol_unseen !== want.symbol_unseen)
					report_mismatch("symbol_unseen", want.symbol_unseen, result.symbol_unseen);
				if (result.too_long !== want.too_long)
					report_mismatch("too_long", want.too_long, result.too_long);
			end
		end
	end

	task automatic test_after_reset();
		send_req(KIND_ENCODE, 8'd0, 1'b0);
		send_req(KIND_ENCODE, 8'd255, 1'b1);
		send_req(KIND_NONE, 8'd255, 1'b1);
	endtask

	task automatic test_directed();
		send_req(KIND_COUNT, 8'd255, 1'b1);
		send_req(KIND_ENCODE, 8'd255, 1'b0);
		send_req(KIND_ENCODE, 8'd7, 1'b0);
		send_req(KIND_COUNT, 8'd0, 1'b0);
		send_req(KIND_ENCODE, 8'd0, 1'b0);
		send_req(KIND_COUNT, 8'd0, 1'b1);
		send_req(KIND_ENCODE, 8'd0, 1'b0);
		send_req(KIND_ENCODE, 8'd255, 1'b0);
		send_req(KIND_COUNT, 8'd128, 1'b0);
		send_req(KIND_COUNT, 8'd1, 1'b1);
		send_req(KIND_ENCODE, 8'd128, 1'b0);
		send_req(KIND_ENCODE, 8'd1, 1'b0);
		send_req(KIND_NONE, 8'd1, 1'b0);
		send_req(KIND_ENCODE, 8'd0, 1'b1);
		send_req(KIND_CLEAR, 8'd255, 1'b1);
		send_req(KIND_ENCODE, 8'd0, 1'b0);
		send_req(KIND_COUNT, 8'd170, 1'b0);
		send_req(KIND_COUNT, 8'd85, 1'b1);
		send_req(KIND_ENCODE, 8'd170, 1'b0);
		send_req(KIND_ENCODE, 8'd85, 1'b1);
		send_req(KIND_CLEAR, 8'd0, 1'b0);
	endtask

	task automatic test_full_alphabet();
		for (int s = 0; s < SYMBOLS; s++)
			send_req(KIND_COUNT, SYM_W'(s), s == SYMBOLS - 1);
		for (int i = 0; i < 40; i++)
			send_req(KIND_ENCODE, SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_req(KIND_ENCODE, 8'd0, 1'b0);
		send_req(KIND_ENCODE, 8'd255, 1'b0);
	endtask

	task automatic test_random_sets(int until_sent);
		logic [SYM_W-1:0] alpha [12];
		int k, n;
		while (n_sent < until_sent) begin
			send_req(KIND_CLEAR, SYM_W'($urandom), 1'($urandom));
			k = $urandom_range(2, 12);
			for (int i = 0; i < k; i++) alpha[i] = SYM_W'($urandom);
			if ($urandom_range(0, 3) == 0) alpha[0] = 8'd255;
			if ($urandom_range(0, 3) == 0) alpha[1] = 8'd0;
			n = $urandom_range(k, 40);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_req(KIND_NONE, SYM_W'($urandom), 1'($urandom));
				send_req(KIND_COUNT, alpha[$urandom_range(0, $urandom_range(0, k - 1))],
				         i == n - 1);
			end
			n = $urandom_range(5, 25);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 15))
					0: send_req(KIND_ENCODE, SYM_W'($urandom), 1'($urandom));
					1: send_req(KIND_NONE, SYM_W'($urandom), 1'($urandom));
					2: send_req(KIND_COUNT, alpha[$urandom_range(0, k - 1)], 1'($urandom));
					default: send_req(KIND_ENCODE, alpha[$urandom_range(0, k - 1)],
					                  1'($urandom));
				endcase
			end
		end
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		burst_left = 40;
		for (int i = 0; i < 30; i++)
			send_req(KIND_ENCODE, SYM_W'($urandom), 1'b0);
	endtask

	initial begin
		for (int i = 0; i < SYMBOLS; i++) hist[i] = 0;
		tree_unlink();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_directed();
		wait_drained();
		test_full_alphabet();
		test_backpressure();
		wait_drained();
		test_random_sets(700);
		test_backpressure();
		test_random_sets(1080);
		wait_drained();
		repeat (100) @(posedge clk);
		$display("sent %0d requests, %0d tree builds, %0d codes checked",
		         n_sent, n_builds, n_codes);
		if (errors == 0 && codes_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
